/* hw/rtl/mcs_pkg.sv */
package mcs_pkg;

  typedef struct packed {
    logic start;
    logic ack;
  } mcs_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mcs_sts_t;

endpackage

/* hw/rtl/mcs_table_mem.sv */
module mcs_table_mem #(
  parameter int AW = 13,
  parameter int DW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  localparam int Depth = 1 << AW;

  logic [DW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hw/rtl/mcs_adj_store.sv */
module mcs_adj_store #(
  parameter int HALF = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [$clog2(2*HALF)-1:0]         wr_row,
  input  logic [2*HALF-1:0]                 wr_bits,
  input  logic                              clr,
  output logic [2*HALF-1:0][2*HALF-1:0]     rows
);

  localparam int Verts = 2 * HALF;

  logic [Verts-1:0] row_r [Verts];
  logic [Verts-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr) begin
      valid_r <= '0;
    end else if (wr_en && (int'(wr_row) < Verts)) begin
      valid_r[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (int'(wr_row) < Verts)) begin
      row_r[wr_row] <= wr_bits;
    end
  end

  always_comb begin
    for (int i = 0; i < Verts; i++) begin
      rows[i] = valid_r[i] ? row_r[i] : '0;
    end
  end

endmodule

/* hw/rtl/mcs_search.sv */
module mcs_search #(
  parameter int HALF = 13
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mcs_pkg::mcs_ctl_t               ctl,
  input  logic [2*HALF-1:0][2*HALF-1:0]   rows,
  output mcs_pkg::mcs_sts_t               sts,
  output logic [$clog2(2*HALF+1)-1:0]     result
);

  localparam int Verts = 2 * HALF;
  localparam int TW = $clog2(HALF + 1);
  localparam int RW = $clog2(2 * HALF + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StBuild = 2'd1;
  localparam logic [1:0] StJoin  = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [HALF:0]   cnt_r, cnt_nxt;
  logic [HALF-1:0] m;
  logic            issue;

  logic [HALF-1:0] vbit, rowv, colv, diag, nbr;
  logic [HALF-1:0] b_addr_a, b_addr_b;
  logic            b_self;
  logic [HALF-1:0] acc_up, acc_lo;
  logic            j_ok;
  logic [TW-1:0]   j_pc;

  logic            s1_v_r;
  logic [HALF-1:0] s1_wa_r, s1_a_r, s1_b_r;
  logic            s1_self_r, s1_ok_r;
  logic [TW-1:0]   s1_pc_r;

  logic            fwd_v_r;
  logic [HALF-1:0] fwd_a_r;
  logic [TW-1:0]   fwd_d_r;

  logic [HALF-1:0] raddr_a;
  logic [TW-1:0]   rdata_a, rdata_b;
  logic [TW-1:0]   da, db, cand, v;
  logic [RW-1:0]   total;
  logic            we;
  logic [RW-1:0]   best_r;

  assign m = cnt_r[HALF-1:0];
  assign issue = ((state_r == StBuild) || (state_r == StJoin)) && !cnt_r[HALF];

  always_comb begin
    vbit = m & (~m + HALF'(1));
    rowv = '0;
    for (int i = 0; i < HALF; i++) begin
      rowv    = rowv | (rows[i][HALF-1:0] & {HALF{vbit[i]}});
      colv[i] = |(rows[i][HALF-1:0] & vbit);
      diag[i] = rows[i][i];
    end
    nbr      = rowv & colv & diag;
    b_addr_a = m & ~vbit;
    b_addr_b = b_addr_a & nbr;
    b_self   = |(vbit & diag);
  end

  always_comb begin
    acc_up = '1;
    acc_lo = '1;
    for (int i = 0; i < HALF; i++) begin
      if (m[i]) begin
        acc_up = acc_up & rows[HALF+i][Verts-1:HALF];
        acc_lo = acc_lo & rows[HALF+i][HALF-1:0];
      end
    end
    j_ok = (m & acc_up) == m;
    j_pc = TW'($countones(m));
  end

  assign raddr_a = (state_r == StJoin) ? acc_lo : b_addr_a;

  mcs_table_mem #(
    .AW(HALF),
    .DW(TW)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (s1_wa_r),
    .wdata   (v),
    .raddr_a (raddr_a),
    .raddr_b (b_addr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // The empty mask is never stored; it always reads as zero.
  always_comb begin
    if (s1_a_r == '0) begin
      da = '0;
    end else if (fwd_v_r && (fwd_a_r == s1_a_r)) begin
      da = fwd_d_r;
    end else begin
      da = rdata_a;
    end
    if (s1_b_r == '0) begin
      db = '0;
    end else if (fwd_v_r && (fwd_a_r == s1_b_r)) begin
      db = fwd_d_r;
    end else begin
      db = rdata_b;
    end
    cand  = s1_self_r ? (db + TW'(1)) : '0;
    v     = (da > cand) ? da : cand;
    total = RW'(s1_pc_r) + RW'(da);
  end

  assign we = s1_v_r && (state_r == StBuild);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      StIdle: begin
        if (ctl.start) begin
          state_nxt = StBuild;
          cnt_nxt   = (HALF+1)'(1);
        end
      end
      StBuild: begin
        if (issue) begin
          cnt_nxt = cnt_r + (HALF+1)'(1);
        end else if (!s1_v_r) begin
          state_nxt = StJoin;
          cnt_nxt   = (HALF+1)'(1);
        end
      end
      StJoin: begin
        if (issue) begin
          cnt_nxt = cnt_r + (HALF+1)'(1);
        end else if (!s1_v_r) begin
          state_nxt = StDone;
        end
      end
      StDone: begin
        if (ctl.ack) begin
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      s1_v_r  <= issue;
      fwd_v_r <= we;
    end
  end

  always_ff @(posedge clk) begin
    s1_wa_r   <= m;
    s1_a_r    <= raddr_a;
    s1_b_r    <= b_addr_b;
    s1_self_r <= b_self;
    s1_ok_r   <= j_ok;
    s1_pc_r   <= j_pc;
    fwd_a_r   <= s1_wa_r;
    fwd_d_r   <= v;
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      best_r <= '0;
    end else if (we && (RW'(v) > best_r)) begin
      best_r <= RW'(v);
    end else if (s1_v_r && (state_r == StJoin) && s1_ok_r && (total > best_r)) begin
      best_r <= total;
    end
  end

  assign sts.busy = state_r != StIdle;
  assign sts.done = state_r == StDone;
  assign result   = best_r;

  a_no_empty_write: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> s1_wa_r != '0)
    else $error("Table write to the empty mask.");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == StDone |-> !s1_v_r)
    else $error("Result offered while a step is still in flight.");

  a_ack_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ack |-> state_r == StDone)
    else $error("Result taken while no search has finished.");

  a_start_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> state_r == StIdle)
    else $error("Search started while busy.");

  a_ack_returns: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ack |=> state_r == StIdle)
    else $error("Search did not return to idle after its result was taken.");

  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == StDone |-> best_r <= RW'(Verts))
    else $error("Clique size exceeds the vertex count.");

endmodule

/* hw/rtl/max_clique_split_search_top.sv */
// Maximum clique search over 2*HALF vertices, split into a lower and an upper half.
// The input channel carries one adjacency row per transaction: the vertex number,
// its neighbor mask (own bit set marks the vertex usable) and a last-row flag.
// Rows load at one per cycle while in_stall is low; a vertex number of 2*HALF
// or more is dropped. The transaction with last_row set starts the search and
// yields one result transaction carrying the clique size; other rows yield nothing.
// The search builds a best-clique table over all non-empty lower-half masks in a
// two-read-port memory, one mask per cycle, then walks all non-empty upper-half
// masks, one per cycle, looking up the table.
// in_stall stays high from the last row until the result has been moved into
// the output register. The adjacency store is then cleared for the next graph.
// The output register holds the result while out_stall is high; the search
// waits in its done state while the register is occupied and out_stall is high.
// Reset clears the adjacency store, the output valid flag and the sequencer.
// The table memory needs no reset since every entry is rebuilt before use.
module max_clique_split_search_top #(
  parameter int HALF = 13
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [$clog2(2*HALF)-1:0]      in_row_number,
  input  logic [2*HALF-1:0]              in_row_bits,
  input  logic                           in_last_row,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [$clog2(2*HALF+1)-1:0]    out_clique_size
);

  localparam int RW = $clog2(2 * HALF + 1);

  mcs_pkg::mcs_ctl_t           ctl;
  mcs_pkg::mcs_sts_t           sts;
  logic [2*HALF-1:0][2*HALF-1:0] rows;
  logic [RW-1:0]               result;
  logic                        accept;
  logic                        out_valid_r;
  logic [RW-1:0]               out_clique_size_r;

  assign in_stall  = sts.busy;
  assign accept    = in_valid && !in_stall;
  assign ctl.start = accept && in_last_row;
  assign ctl.ack   = sts.done && (!out_valid_r || !out_stall);

  mcs_adj_store #(
    .HALF(HALF)
  ) u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_row  (in_row_number),
    .wr_bits (in_row_bits),
    .clr     (ctl.ack),
    .rows    (rows)
  );

  mcs_search #(
    .HALF(HALF)
  ) u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .rows   (rows),
    .sts    (sts),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.ack) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ack) begin
      out_clique_size_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_clique_size = out_clique_size_r;

endmodule
